/* hw/rtl/prstb_pkg.sv */
package prstb_pkg;

    // Coordinate and trig word types
    typedef logic signed [31:0] coord_t;
    typedef logic signed [17:0] trig_t;

    // Configuration register indexes
    localparam logic [3:0] CFG_CENTER_X = 4'd0;
    localparam logic [3:0] CFG_CENTER_Y = 4'd1;
    localparam logic [3:0] CFG_COS      = 4'd2;
    localparam logic [3:0] CFG_SIN      = 4'd3;
    localparam logic [3:0] CFG_SCALE_X  = 4'd4;
    localparam logic [3:0] CFG_SCALE_Y  = 4'd5;
    localparam logic [3:0] CFG_POS_X    = 4'd6;
    localparam logic [3:0] CFG_POS_Y    = 4'd7;

    // Saturation bounds, widened to the largest intermediate
    localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = 48'shFFFF_8000_0000;

    // Rotation settings used by the front end
    typedef struct packed {
        coord_t center_x;
        coord_t center_y;
        trig_t  cos_angle;
        trig_t  sin_angle;
    } front_cfg_t;

    // Scale and offset settings used by the back end
    typedef struct packed {
        coord_t scale_x;
        coord_t scale_y;
        coord_t pos_x;
        coord_t pos_y;
    } back_cfg_t;

    // Rotated point queued between front and back
    typedef struct packed {
        logic   frame_start;
        coord_t rot_y;
        coord_t rot_x;
    } rot_word_t;

    // Clamp a signed value to the 32-bit coordinate range
    function automatic coord_t sat32(input logic signed [47:0] v);
        coord_t r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/point_rotate_scale_translate_bbox_top.sv */
// An accepted s_ word passes the front-end states (multiply, sum, center, push), the queue
// and the back-end sequencer (scale multiply, round, translate, box update, output load)
// to m_tdata; each sequencer takes a new word only after it has finished the last one.
// The rotation queue holds FIFO_DEPTH words so the front keeps working while m_ stalls.
// Reset (rst_n, async, active low) restores the default settings and clears the
// bounding box, the queue and the output valid flag.
module point_rotate_scale_translate_bbox_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,    // point_x [31:0], point_y [63:32]
    input  logic         s_tuser,    // frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,    // out_x, out_y, box_width, box_height
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import prstb_pkg::*;

    front_cfg_t front_cfg_reg;
    back_cfg_t  back_cfg_reg;
    rot_word_t  push_word, pop_word;
    logic       push_valid, push_ready, pop_valid, pop_ready;

    assign cfg_ready = 1'b1;

    // Settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cfg_reg.center_x  <= '0;
            front_cfg_reg.center_y  <= '0;
            front_cfg_reg.cos_angle <= 18'sd65536;
            front_cfg_reg.sin_angle <= '0;
            back_cfg_reg.scale_x    <= 32'sd65536;
            back_cfg_reg.scale_y    <= 32'sd65536;
            back_cfg_reg.pos_x      <= '0;
            back_cfg_reg.pos_y      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: front_cfg_reg.center_x  <= cfg_data;
                CFG_CENTER_Y: front_cfg_reg.center_y  <= cfg_data;
                CFG_COS:      front_cfg_reg.cos_angle <= cfg_data[17:0];
                CFG_SIN:      front_cfg_reg.sin_angle <= cfg_data[17:0];
                CFG_SCALE_X:  back_cfg_reg.scale_x    <= cfg_data;
                CFG_SCALE_Y:  back_cfg_reg.scale_y    <= cfg_data;
                CFG_POS_X:    back_cfg_reg.pos_x      <= cfg_data;
                CFG_POS_Y:    back_cfg_reg.pos_y      <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Rotation about the center
    prstb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (front_cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_flag    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    // Queue of rotated points
    prstb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    // Scale, translate, bounding box
    prstb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (back_cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

/* hw/rtl/prstb_front.sv */
module prstb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  prstb_pkg::front_cfg_t cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [63:0]           in_data,    // point_x, point_y
    input  logic                  in_flag,    // frame_start
    output logic                  push_valid,
    input  logic                  push_ready,
    output prstb_pkg::rot_word_t  push_word
);
    import prstb_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_SUM  = 5'b00100,
        F_CEN  = 5'b01000,
        F_PUSH = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic signed [32:0] dx_reg, dy_reg;
    logic               fs_reg;
    logic signed [50:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [35:0] rsum_x_reg, rsum_y_reg;
    coord_t             rot_x_reg, rot_y_reg;

    coord_t             pt_x, pt_y;
    logic signed [32:0] dx_next, dy_next;
    logic signed [50:0] p_xc_next, p_ys_next, p_xs_next, p_yc_next;
    logic signed [51:0] sum_x, sum_y, rnd_x, rnd_y;
    logic signed [36:0] cen_x, cen_y;
    coord_t             rot_x_next, rot_y_next;

    assign pt_x = in_data[31:0];
    assign pt_y = in_data[63:32];

    // Offset from the rotation center, exact in 33 bits
    assign dx_next = 33'(pt_x) - 33'(cfg.center_x);
    assign dy_next = 33'(pt_y) - 33'(cfg.center_y);

    // Four rotation products
    assign p_xc_next = dx_reg * cfg.cos_angle;
    assign p_ys_next = dy_reg * cfg.sin_angle;
    assign p_xs_next = dx_reg * cfg.sin_angle;
    assign p_yc_next = dy_reg * cfg.cos_angle;

    // Sum and round half up by 16 bits
    assign sum_x = 52'(p_xc_reg) - 52'(p_ys_reg);
    assign sum_y = 52'(p_xs_reg) + 52'(p_yc_reg);
    assign rnd_x = sum_x + 52'sd32768;
    assign rnd_y = sum_y + 52'sd32768;

    // Add center back and clamp
    assign cen_x      = 37'(rsum_x_reg) + 37'(cfg.center_x);
    assign cen_y      = 37'(rsum_y_reg) + 37'(cfg.center_y);
    assign rot_x_next = sat32(48'(cen_x));
    assign rot_y_next = sat32(48'(cen_y));

    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_word  = '{frame_start: fs_reg, rot_y: rot_y_reg, rot_x: rot_x_reg};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:  state_next = F_SUM;
            F_SUM:  state_next = F_CEN;
            F_CEN:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            fs_reg <= in_flag;
        end
        if (state_reg == F_MUL)
        begin
            p_xc_reg <= p_xc_next;
            p_ys_reg <= p_ys_next;
            p_xs_reg <= p_xs_next;
            p_yc_reg <= p_yc_next;
        end
        if (state_reg == F_SUM)
        begin
            rsum_x_reg <= rnd_x[51:16];
            rsum_y_reg <= rnd_y[51:16];
        end
        if (state_reg == F_CEN)
        begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
        end
    end

endmodule

/* hw/rtl/prstb_fifo.sv */
module prstb_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  prstb_pkg::rot_word_t push_word,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output prstb_pkg::rot_word_t pop_word
);
    import prstb_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    rot_word_t         mem [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_word   = mem[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* hw/rtl/prstb_back.sv */
module prstb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  prstb_pkg::back_cfg_t cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  prstb_pkg::rot_word_t pop_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [127:0]         out_data    // out_x, out_y, box_width, box_height
);
    import prstb_pkg::*;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MUL  = 6'b000010,
        B_SCL  = 6'b000100,
        B_ADD  = 6'b001000,
        B_BOX  = 6'b010000,
        B_EMIT = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;

    coord_t             rot_x_reg, rot_y_reg;
    logic               fs_reg;
    logic signed [63:0] prod_x_reg, prod_y_reg;
    coord_t             sx_reg, sy_reg;
    coord_t             ox_reg, oy_reg;
    coord_t             min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic               box_valid_reg, box_valid_next;
    logic               out_valid_reg, out_valid_next;
    coord_t             out_x_reg, out_y_reg;
    logic [31:0]        width_reg, height_reg;

    logic signed [63:0] prod_x_next, prod_y_next, rnd_x, rnd_y;
    logic signed [32:0] sum_x, sum_y;
    logic               restart, out_free;

    // Scale products
    assign prod_x_next = rot_x_reg * cfg.scale_x;
    assign prod_y_next = rot_y_reg * cfg.scale_y;

    // Round half up by 16 bits
    assign rnd_x = prod_x_reg + 64'sd32768;
    assign rnd_y = prod_y_reg + 64'sd32768;

    // Translation
    assign sum_x = 33'(sx_reg) + 33'(cfg.pos_x);
    assign sum_y = 33'(sy_reg) + 33'(cfg.pos_y);

    assign restart   = fs_reg || !box_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = {height_reg, width_reg, out_y_reg, out_x_reg};

    // Sequencer and output word handshake
    always_comb
    begin
        state_next     = state_reg;
        box_valid_next = box_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:  state_next = B_SCL;
            B_SCL:  state_next = B_ADD;
            B_ADD:  state_next = B_BOX;
            B_BOX:
            begin
                box_valid_next = 1'b1;
                state_next     = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            box_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_valid_reg <= box_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Bounding box extremes; zero at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end
        else if (state_reg == B_BOX)
        begin
            min_x_reg <= (restart || ox_reg < min_x_reg) ? ox_reg : min_x_reg;
            max_x_reg <= (restart || ox_reg > max_x_reg) ? ox_reg : max_x_reg;
            min_y_reg <= (restart || oy_reg < min_y_reg) ? oy_reg : min_y_reg;
            max_y_reg <= (restart || oy_reg > max_y_reg) ? oy_reg : max_y_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid)
        begin
            rot_x_reg <= pop_word.rot_x;
            rot_y_reg <= pop_word.rot_y;
            fs_reg    <= pop_word.frame_start;
        end
        if (state_reg == B_MUL)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (state_reg == B_SCL)
        begin
            sx_reg <= sat32(rnd_x[63:16]);
            sy_reg <= sat32(rnd_y[63:16]);
        end
        if (state_reg == B_ADD)
        begin
            ox_reg <= sat32(48'(sum_x));
            oy_reg <= sat32(48'(sum_y));
        end
        if (state_reg == B_EMIT && out_free)
        begin
            out_x_reg  <= ox_reg;
            out_y_reg  <= oy_reg;
            width_reg  <= max_x_reg - min_x_reg;
            height_reg <= max_y_reg - min_y_reg;
        end
    end

endmodule
